// ===== design/kdhr_pkg.sv =====
package kdhr_pkg;

  // Item field widths
  localparam int unsigned PadW   = 2;
  localparam int unsigned NowW   = 32;
  localparam int unsigned KeyW   = 2;

  // Stream data widths, padded to whole bytes
  localparam int unsigned SDataW = ((PadW + NowW + 7) / 8) * 8;
  localparam int unsigned MDataW = ((KeyW + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegDebounce = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegHold     = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegRepeat   = CfgIdxW'(2);

  localparam logic [CfgDataW-1:0] DebounceRst = CfgDataW'(50);
  localparam logic [CfgDataW-1:0] HoldRst     = CfgDataW'(800);
  localparam logic [CfgDataW-1:0] RepeatRst   = CfgDataW'(200);

  // Timing settings handed to the key tracker
  typedef struct packed {
    logic [CfgDataW-1:0] debounce_ms;
    logic [CfgDataW-1:0] hold_ms;
    logic [CfgDataW-1:0] repeat_ms;
  } cfg_t;

endpackage

// ===== design/kdhr_core.sv =====
module kdhr_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [kdhr_pkg::PadW-1:0] pad_code_i,
  input  logic [TIME_BITS-1:0]     now_i,
  input  kdhr_pkg::cfg_t           cfg_i,
  output logic [kdhr_pkg::KeyW-1:0] key_event_o
);
  import kdhr_pkg::*;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhBounce  = 2'd1,
    PhPressed = 2'd2
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [TIME_BITS-1:0] settle_start_q, settle_start_d;
  logic [TIME_BITS-1:0] press_start_q, press_start_d;
  logic [TIME_BITS-1:0] repeat_start_q, repeat_start_d;
  logic [PadW-1:0]      held_key_q, held_key_d;
  logic                 hold_active_q, hold_active_d;
  logic [KeyW-1:0]      key_event_q, key_event_d;

  logic [TIME_BITS-1:0] since_settle, since_press, since_repeat;
  logic                 settled, hold_due, repeat_due;

  // Elapsed times wrap with the timestamp width
  assign since_settle = now_i - settle_start_q;
  assign since_press  = now_i - press_start_q;
  assign since_repeat = now_i - repeat_start_q;

  assign settled    = since_settle >= TIME_BITS'(cfg_i.debounce_ms);
  assign hold_due   = since_press  >= TIME_BITS'(cfg_i.hold_ms);
  assign repeat_due = since_repeat >= TIME_BITS'(cfg_i.repeat_ms);

  // Step the key tracker for one sample
  always_comb begin
    phase_d        = phase_q;
    settle_start_d = settle_start_q;
    press_start_d  = press_start_q;
    repeat_start_d = repeat_start_q;
    held_key_d     = held_key_q;
    hold_active_d  = hold_active_q;
    key_event_d    = '0;
    case (phase_q)
      PhBounce: begin
        if (settled) begin
          if (pad_code_i != '0) begin
            phase_d       = PhPressed;
            press_start_d = now_i;
            held_key_d    = pad_code_i;
            key_event_d   = KeyW'(pad_code_i);
          end else begin
            phase_d = PhIdle;
          end
        end
      end
      PhPressed: begin
        if (pad_code_i == '0) begin
          // release: settle again before going idle
          phase_d        = PhBounce;
          settle_start_d = now_i;
          hold_active_d  = 1'b0;
        end else if (pad_code_i == held_key_q) begin
          if (!hold_active_q) begin
            if (hold_due) begin
              hold_active_d  = 1'b1;
              repeat_start_d = now_i;
              key_event_d    = KeyW'(pad_code_i);
            end
          end else if (repeat_due) begin
            repeat_start_d = now_i;
            key_event_d    = KeyW'(pad_code_i);
          end
        end
      end
      default: begin
        // idle, and the unused encoding behaves as idle
        if (pad_code_i != '0) begin
          phase_d        = PhBounce;
          settle_start_d = now_i;
        end
      end
    endcase
  end

  // Hold state and the reported key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhIdle;
      settle_start_q <= '0;
      press_start_q  <= '0;
      repeat_start_q <= '0;
      held_key_q     <= '0;
      hold_active_q  <= 1'b0;
      key_event_q    <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      settle_start_q <= settle_start_d;
      press_start_q  <= press_start_d;
      repeat_start_q <= repeat_start_d;
      held_key_q     <= held_key_d;
      hold_active_q  <= hold_active_d;
      key_event_q    <= key_event_d;
    end
  end

  assign key_event_o = key_event_q;

endmodule

// ===== design/key_debounce_hold_repeat_unit.sv =====
// Button debounce with hold and auto-repeat. Each input item is one sample of
// the 2-bit button pad code with a free-running millisecond timestamp; each
// sample yields exactly one output item holding the reported key code, 0 when
// nothing is reported. A new press must stay for debounce_ms before it is
// reported, holding it reports again after hold_ms and then every repeat_ms,
// and a release must settle for debounce_ms. Timestamp differences wrap at
// TIME_BITS bits. The block takes one item per cycle while results are taken; an
// item's result is offered after the item has passed the input register and the
// single state step has loaded the result register. A stalled result holds the
// input register, so the input side stalls only while both registers are full.
// Write the timing registers only while no items are in flight.
module key_debounce_hold_repeat_unit #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [kdhr_pkg::SDataW-1:0]     s_axis_tdata,   // pad_code, now_ms, zero fill
  // result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [kdhr_pkg::MDataW-1:0]     m_axis_tdata,   // key_event, zero fill
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kdhr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [kdhr_pkg::CfgDataW-1:0]   cfg_data_i
);
  import kdhr_pkg::*;

  cfg_t            cfg_q;
  logic            in_valid_q;
  logic [PadW-1:0] pad_q;
  logic [NowW-1:0] now_q;
  logic            out_valid_q;
  logic            advance;
  logic [KeyW-1:0] key_event;

  // Move the held item into the result register when there is room
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Write timing registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= DebounceRst;
      cfg_q.hold_ms     <= HoldRst;
      cfg_q.repeat_ms   <= RepeatRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDebounce: cfg_q.debounce_ms <= cfg_data_i;
        RegHold:     cfg_q.hold_ms     <= cfg_data_i;
        RegRepeat:   cfg_q.repeat_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      pad_q <= s_axis_tdata[PadW-1:0];
      now_q <= s_axis_tdata[PadW+NowW-1:PadW];
    end
  end

  // Result valid follows the step and drops when the item is taken with none behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  kdhr_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_valid_q && advance),
    .pad_code_i (pad_q),
    .now_i      (TIME_BITS'(now_q)),
    .cfg_i      (cfg_q),
    .key_event_o(key_event)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = MDataW'(key_event);

endmodule

// ===== design/kdhr_checker.sv =====
module kdhr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [kdhr_pkg::MDataW-1:0] m_axis_tdata
);
  import kdhr_pkg::*;

  // Result must stay offered while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item dropped or changed while stalled");

  // Input side only stalls behind a stalled full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // Every accepted item leads to an offered result through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
    else $error("accepted item produced no result");

  // Nothing is offered right out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result offered out of reset");

endmodule

bind key_debounce_hold_repeat_unit kdhr_checker u_kdhr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== tb/key_event_board_pkg.sv =====
package key_event_board_pkg;
  import kdhr_pkg::*;

  typedef enum logic [1:0] {
    PhIdle,
    PhBounce,
    PhPressed
  } key_phase_e;

  // Tracks the debounce/hold/repeat state and holds the key events still due
  class key_event_board;
    cfg_t            timing;
    key_phase_e      phase;
    logic [NowW-1:0] settle_start;
    logic [NowW-1:0] press_start;
    logic [NowW-1:0] repeat_start;
    logic [PadW-1:0] held_key;
    logic            hold_active;
    logic [KeyW-1:0] expected_events[$];
    int unsigned     failures;

    function new();
      timing.debounce_ms = DebounceRst;
      timing.hold_ms     = HoldRst;
      timing.repeat_ms   = RepeatRst;
      phase        = PhIdle;
      settle_start = '0;
      press_start  = '0;
      repeat_start = '0;
      held_key     = '0;
      hold_active  = 1'b0;
      failures     = 0;
    endfunction

    // Mirror a register write; unknown indexes are dropped
    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegDebounce: timing.debounce_ms = val;
        RegHold:     timing.hold_ms     = val;
        RegRepeat:   timing.repeat_ms   = val;
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_events.size();
    endfunction

    // Advance the key state by one accepted sample and queue its event
    function void note_sample(logic [PadW-1:0] pad, logic [NowW-1:0] now);
      logic [KeyW-1:0] key_event;
      logic [NowW-1:0] since;
      key_event = '0;
      case (phase)
        PhBounce: begin
          since = now - settle_start;
          if (since >= NowW'(timing.debounce_ms)) begin
            if (pad != '0) begin
              phase       = PhPressed;
              press_start = now;
              held_key    = pad;
              key_event   = pad;
            end else begin
              phase = PhIdle;
            end
          end
        end
        PhPressed: begin
          if (pad == '0) begin
            // release must settle again
            phase        = PhBounce;
            settle_start = now;
            hold_active  = 1'b0;
          end else if (pad == held_key) begin
            if (!hold_active) begin
              since = now - press_start;
              if (since >= NowW'(timing.hold_ms)) begin
                hold_active  = 1'b1;
                repeat_start = now;
                key_event    = pad;
              end
            end else begin
              since = now - repeat_start;
              if (since >= NowW'(timing.repeat_ms)) begin
                repeat_start = now;
                key_event    = pad;
              end
            end
          end
        end
        default: begin
          if (pad != '0) begin
            phase        = PhBounce;
            settle_start = now;
          end
        end
      endcase
      expected_events.push_back(key_event);
    endfunction

    // Compare one result item against the oldest queued event
    function void check_event(logic [MDataW-1:0] tdata);
      logic [KeyW-1:0] got;
      logic [KeyW-1:0] want;
      got = tdata[KeyW-1:0];
      if (expected_events.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected key_event %0d with no sample outstanding", got);
        end
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10) begin
            $display("key_event mismatch: expected %0d, got %0d", want, got);
          end
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_key_debounce_hold_repeat_unit.sv =====
module tb_key_debounce_hold_repeat_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import kdhr_pkg::*;
  import key_event_board_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = CfgIdxW'(3);
  localparam int unsigned DrainCycles = 6;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_ready;
  logic [SDataW-1:0]   s_tdata   = '0;
  logic                m_valid;
  logic                m_ready   = 1'b0;
  logic [MDataW-1:0]   m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  bit                  no_gaps   = 1'b0;
  logic [NowW-1:0]     clock_ms  = '0;
  int unsigned         phase_samples = 0;
  key_event_board      board = new();

  key_debounce_hold_repeat_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Present one sample, with occasional idle cycles ahead of it
  task automatic send_sample(input logic [PadW-1:0] pad, input logic [NowW-1:0] now);
    while (!no_gaps && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= SDataW'({now, pad});
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    board.note_sample(pad, now);
    phase_samples++;
  endtask

  task automatic send_at(input logic [PadW-1:0] pad, input logic [NowW-1:0] stamp);
    clock_ms = stamp;
    send_sample(pad, stamp);
  endtask

  task automatic send_after(input logic [PadW-1:0] pad, input logic [NowW-1:0] delta);
    clock_ms = clock_ms + delta;
    send_sample(pad, clock_ms);
  endtask

  // Pick a time step that lands on, just short of, or around a threshold
  function automatic logic [NowW-1:0] near(input logic [CfgDataW-1:0] lim);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return NowW'(lim);
    if (pick < 4 && lim != '0) return NowW'(lim - 1'b1);
    return NowW'($urandom_range(0, 32'(lim) + 32'(lim) / 2 + 2));
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    board.set_reg(idx, val);
  endtask

  task automatic program_timing(input logic [CfgDataW-1:0] dbn,
                                input logic [CfgDataW-1:0] hold,
                                input logic [CfgDataW-1:0] rep,
                                input bit poke_unused);
    write_reg(RegDebounce, dbn);
    write_reg(RegHold, hold);
    write_reg(RegRepeat, rep);
    if (poke_unused) write_reg(RegUnused, CfgDataW'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every queued event has come back, then let the pipe empty
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.outstanding() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One press: chatter, settle, hold with repeats, release, chatter, settle
  task automatic press_cycle();
    logic [PadW-1:0]     key;
    logic [CfgDataW-1:0] lim;
    logic [CfgDataW-1:0] dbn;
    dbn = board.timing.debounce_ms;
    key = PadW'($urandom_range(1, 3));
    send_after(key, $urandom_range(0, 3000));
    repeat ($urandom_range(0, 3)) begin
      send_after(PadW'($urandom_range(0, 3)), $urandom_range(0, 32'(dbn) / 2));
    end
    send_after(key, near(dbn));
    repeat ($urandom_range(1, 12)) begin
      lim = board.hold_active ? board.timing.repeat_ms : board.timing.hold_ms;
      if ($urandom_range(0, 9) == 0) begin
        send_after(PadW'($urandom_range(0, 3)), near(lim));
      end else begin
        send_after(key, near(lim));
      end
    end
    send_after('0, $urandom_range(0, 32'(board.timing.repeat_ms)));
    repeat ($urandom_range(0, 2)) begin
      send_after(PadW'($urandom_range(0, 3)), $urandom_range(0, 32'(dbn) / 2));
    end
    send_after('0, near(dbn));
  endtask

  // Random codes, with occasional jumps of the timestamp anywhere in its range
  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
      send_after(PadW'($urandom_range(0, 3)), $urandom_range(0, 100));
    end
  endtask

  task automatic run_timing(input logic [CfgDataW-1:0] dbn,
                            input logic [CfgDataW-1:0] hold,
                            input logic [CfgDataW-1:0] rep,
                            input int unsigned count,
                            input bit poke_unused);
    bit paused;
    paused = 1'b0;
    drain_results();
    program_timing(dbn, hold, rep, poke_unused);
    phase_samples = 0;
    while (phase_samples < count) begin
      if ($urandom_range(0, 99) < 85) press_cycle();
      else noise_burst();
      if (!paused && phase_samples >= count / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  // Result side: check accepted items, stall at random
  initial begin : result_side
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_valid && m_ready) board.check_event(m_tdata);
      m_ready <= no_gaps || ($urandom_range(0, 99) >= 7);
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through the phases at reset timing
    send_at(2'd0, 32'd0);
    send_at(2'd0, 32'hFFFF_FFFF);
    send_at(2'd1, 32'd1000);           // press opens the debounce window
    send_at(2'd2, 32'd1020);           // chatter inside the window
    send_at(2'd1, 32'd1049);           // one short of the window
    send_at(2'd1, 32'd1050);           // window closes on the boundary
    send_at(2'd2, 32'd1100);           // other key while pressed is ignored
    send_at(2'd3, 32'd1200);
    send_at(2'd1, 32'd1849);           // one short of hold
    send_at(2'd1, 32'd1850);           // hold reached
    send_at(2'd1, 32'd2049);
    send_at(2'd1, 32'd2050);           // first repeat
    send_at(2'd1, 32'd2250);
    send_at(2'd0, 32'd2300);           // release
    send_at(2'd0, 32'd2349);
    send_at(2'd0, 32'd2350);           // release settled, back to idle
    send_at(2'd3, 32'hFFFF_FFE0);      // press across the timestamp wrap
    send_at(2'd3, 32'h0000_0012);
    send_at(2'd3, 32'h0000_0331);
    send_at(2'd3, 32'h0000_0332);
    send_at(2'd0, 32'h0000_0400);
    send_at(2'd2, 32'h0000_0500);      // new key when the release window ends

    // Zero windows, then widest windows with no idling on either side
    run_timing('0, '0, '0, 110, 1'b1);
    no_gaps = 1'b1;
    run_timing('1, '1, '1, 110, 1'b0);
    no_gaps = 1'b0;
    run_timing(16'd5, 16'd30, 16'd10, 110, 1'b0);
    run_timing(16'd1, 16'd2, 16'd0, 90, 1'b0);
    run_timing(CfgDataW'($urandom_range(0, 200)), CfgDataW'($urandom_range(0, 1000)),
               CfgDataW'($urandom_range(0, 300)), 100, 1'b1);
    run_timing(CfgDataW'($urandom()), CfgDataW'($urandom()),
               CfgDataW'($urandom()), 60, 1'b0);
    run_timing(DebounceRst, HoldRst, RepeatRst, 80, 1'b0);
    drain_results();

    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("key_debounce_hold_repeat_unit regression: pass");
    end else begin
      $display("key_debounce_hold_repeat_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("key_debounce_hold_repeat_unit regression: fail");
    $finish;
  end

endmodule
